FILE: sv/sparse_matrix_entry_table_macros.svh
// assertion macros for the sparse matrix entry table checker
`ifndef SPARSE_MATRIX_ENTRY_TABLE_MACROS_SVH
`define SPARSE_MATRIX_ENTRY_TABLE_MACROS_SVH

// same-cycle implication, off while reset is high
`define SMET_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define SMET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/smet_pkg.sv
// shared types and constants for the sparse matrix entry table
package smet_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int KEY_W            = 32;
  localparam int DATA_W           = 32;
  localparam int COORD_W          = 16;
  localparam int COUNT_W          = 7;

  // operation codes; code 3 is a no-op
  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_GET    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] row_index;
    logic [COORD_W-1:0] col_index;
    logic [DATA_W-1:0]  data_in;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  data_out;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  // one table slot as stored in memory
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } slot_entry_t;

endpackage

FILE: sv/smet_mem.sv
// slot memory: one write port, one registered read port
module smet_mem
  import smet_pkg::*;
#(
  parameter int DEPTH  = CAPACITY_DEFAULT,
  parameter int ADDR_W = $clog2(CAPACITY_DEFAULT)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output slot_entry_t       rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  slot_entry_t       wr_data
);

  slot_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered and loaded only while rd_en is high
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/smet_ctrl.sv
// scan sequencer: clears, scans slots, writes back and issues results
module smet_ctrl
  import smet_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT,
  parameter int IDX_W    = $clog2(CAPACITY_DEFAULT),
  parameter int CNT_W    = $clog2(CAPACITY_DEFAULT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  req_t              req_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rsp_t              rsp_data,
  input  logic [DATA_W-1:0] default_value,
  output logic              mem_rd_en,
  output logic [IDX_W-1:0]  mem_rd_addr,
  input  slot_entry_t       mem_rd_data,
  output logic              mem_wr_en,
  output logic [IDX_W-1:0]  mem_wr_addr,
  output slot_entry_t       mem_wr_data
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  state_t             state;
  req_t               req_q;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   iss_idx;
  logic               iss_done;
  logic               chk_valid;
  logic [IDX_W-1:0]   chk_idx;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [DATA_W-1:0]  hit_value;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  logic               fin_fire;
  logic               fin_wr;
  logic [IDX_W-1:0]   fin_addr;
  slot_entry_t        fin_entry;
  status_t            fin_status;
  logic [DATA_W-1:0]  fin_dout;
  logic [CNT_W-1:0]   count_next;
  logic [KEY_W-1:0]   req_key;
  logic               key_match;

  assign req_key   = {req_q.row_index, req_q.col_index};
  assign key_match = mem_rd_data.valid && (mem_rd_data.key == req_key);
  assign in_stall  = (state != S_IDLE);

  // result slot is free when empty or being taken this cycle
  assign fin_fire = (state == S_FINISH) && (!out_valid || !out_stall);

  // read one slot per cycle during the scan
  assign mem_rd_en   = (state == S_SCAN) && !iss_done;
  assign mem_rd_addr = iss_idx;

  // outcome of the finished scan
  always_comb begin
    fin_wr     = 1'b0;
    fin_addr   = hit_idx;
    fin_entry  = '{valid: 1'b1, key: req_key, value: req_q.data_in};
    fin_status = ST_OK;
    fin_dout   = '0;
    count_next = count;
    case (req_q.kind)
      KIND_PUT: begin
        if (hit) begin
          fin_wr = 1'b1;
        end else if (free_found) begin
          fin_wr     = 1'b1;
          fin_addr   = free_idx;
          count_next = count + CNT_W'(1);
        end else begin
          fin_status = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (count == '0) begin
          fin_status = ST_EMPTY;
        end else if (hit) begin
          fin_wr          = 1'b1;
          fin_entry.valid = 1'b0;
          count_next      = count - CNT_W'(1);
        end
      end
      KIND_GET: begin
        if (hit) begin
          fin_dout = hit_value;
        end else begin
          fin_status = ST_NOT_FOUND;
          fin_dout   = default_value;
        end
      end
      default: begin
      end
    endcase
  end

  // memory write: clearing pass or write-back
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = fin_addr;
    mem_wr_data = fin_entry;
    if (state == S_CLEAR) begin
      mem_wr_en         = 1'b1;
      mem_wr_addr       = iss_idx;
      mem_wr_data       = '0;
    end else if (fin_fire) begin
      mem_wr_en = fin_wr;
    end
  end

  // sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      count      <= '0;
      iss_idx    <= '0;
      iss_done   <= 1'b0;
      chk_valid  <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // response register: loaded on finish, emptied when taken
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (iss_idx == LAST_IDX) begin
            iss_idx <= '0;
            state   <= S_IDLE;
          end else begin
            iss_idx <= iss_idx + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_q      <= req_data;
            iss_idx    <= '0;
            iss_done   <= 1'b0;
            chk_valid  <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue side
          chk_valid <= !iss_done;
          chk_idx   <= iss_idx;
          if (!iss_done) begin
            iss_idx <= iss_idx + IDX_W'(1);
            if (iss_idx == LAST_IDX) begin
              iss_done <= 1'b1;
            end
          end
          // compare side
          if (chk_valid) begin
            if (key_match && !hit) begin
              hit       <= 1'b1;
              hit_idx   <= chk_idx;
              hit_value <= mem_rd_data.value;
            end
            if (!mem_rd_data.valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_idx;
            end
            if (iss_done) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (fin_fire) begin
            count                <= count_next;
            rsp_data.status      <= fin_status;
            rsp_data.data_out    <= fin_dout;
            rsp_data.entry_count <= COUNT_W'(count_next);
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/sparse_matrix_entry_table.sv
// sparse matrix entry table, top level
// Each request (put, remove or get on a row/column cell) scans the whole slot
// memory through its single read port, one slot per cycle, before its response
// is registered; the next request is taken the cycle after. The response sits
// in an output register, so a new request is accepted while the previous
// response waits.
// After reset the slot memory is cleared one slot per cycle, with in_stall
// high; default_value writes are taken during that time.
module sparse_matrix_entry_table
  import smet_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  req_t              req_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rsp_t              rsp_data,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [DATA_W-1:0] default_value;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  slot_entry_t       mem_rd_data;
  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  slot_entry_t       mem_wr_data;

  // default value register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_value <= '0;
    end else if (cfg_wr_en) begin
      default_value <= cfg_wr_data;
    end
  end

  smet_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  smet_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_data      (req_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .rsp_data      (rsp_data),
    .default_value (default_value),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data)
  );

endmodule

FILE: sv/smet_checker.sv
// port-level checker for the sparse matrix entry table, bound to the top level
`include "sparse_matrix_entry_table_macros.svh"

module smet_checker
  import smet_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input rsp_t rsp_data
);

  // a stalled response holds
  `SMET_ASSERT_NEXT(a_rsp_hold, clk, rst, out_valid && out_stall,
                    out_valid && $stable(rsp_data), "stalled response changed")

  // slot memory is being cleared right after reset
  `SMET_ASSERT_NOW(a_clear_stall, clk, rst, $past(rst), in_stall,
                   "request taken during clearing pass")

  // a taken request keeps the input busy during its scan
  `SMET_ASSERT_NEXT(a_busy_after_req, clk, rst, in_valid && !in_stall, in_stall,
                    "input not stalled after a request")

  // empty status only with no entries
  `SMET_ASSERT_NOW(a_empty_count, clk, rst, out_valid && (rsp_data.status == ST_EMPTY),
                   rsp_data.entry_count == '0, "empty status with nonzero count")

  // full status only when every slot is taken
  `SMET_ASSERT_NOW(a_full_count, clk, rst, out_valid && (rsp_data.status == ST_FULL),
                   rsp_data.entry_count == COUNT_W'(CAPACITY), "full status with free slots")

endmodule

bind sparse_matrix_entry_table smet_checker #(
  .CAPACITY (CAPACITY)
) u_smet_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .rsp_data  (rsp_data)
);
